// ===== hw/rtl/plr_pkg.sv =====
// shared types and constants for the positional insert/remove list
package plr_pkg;

  // item field widths
  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
    status_t           status;
  } res_t;

endpackage

// ===== hw/rtl/plr_if.sv =====
// valid/ready channel interfaces for list operations and results
interface plr_in_if;
  logic                         valid;
  logic                         ready;
  logic [plr_pkg::OP_W-1:0]     op;
  logic [plr_pkg::POS_W-1:0]    position;
  logic [plr_pkg::VAL_W-1:0]    value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface plr_out_if;
  logic                         valid;
  logic                         ready;
  logic [plr_pkg::DATA_W-1:0]   data;
  logic [plr_pkg::CNT_W-1:0]    count;
  logic                         empty_res;
  logic [plr_pkg::ST_W-1:0]     status;

  modport source (output valid, output data, output count, output empty_res, output status,
                  input ready);
  modport sink   (input valid, input data, input count, input empty_res, input status,
                  output ready);
endinterface

// ===== hw/rtl/plr_mem.sv =====
// entry store: one write port, one registered read port
module plr_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/plr_ctrl.sv =====
// sequencer: range checks and entry shifting through the store, one step at a time
module plr_ctrl #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  plr_in_if.sink           in_chan,
  output logic             res_valid,
  input  logic             res_ready,
  output plr_pkg::res_t    res,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [WIDTH-1:0] wr_data,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  logic [WIDTH-1:0] rd_data
);

  import plr_pkg::*;

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PCW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_RM_WAIT,
    S_DN_RD,
    S_DN_WR,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    lim_r;
  logic [AW-1:0]    p0_r;
  logic [WIDTH-1:0] val_r;
  logic [WIDTH-1:0] data_r;
  logic             dn_r;
  status_t          status_r;

  logic [PCW-1:0]   pos_ext;
  logic [PCW-1:0]   cnt_ext;
  logic             pos_nz;
  logic             acc_ok;
  logic             ins_ok;
  logic             full;
  logic             append;
  logic [AW-1:0]    p0;
  logic             accept;
  logic [CW-1:0]    idx_step;

  // position checks against the current count
  assign pos_ext = PCW'(in_chan.position);
  assign cnt_ext = PCW'(count_r);
  assign pos_nz  = (in_chan.position != '0);
  assign acc_ok  = pos_nz && (pos_ext <= cnt_ext);
  assign ins_ok  = pos_nz && (pos_ext <= cnt_ext + PCW'(1));
  assign full    = (count_r == CW'(DEPTH));
  assign append  = (cnt_ext == pos_ext - PCW'(1));
  assign p0      = AW'(in_chan.position - POS_W'(1));

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // shared index stepper: down for insert shifting, up for remove shifting
  assign idx_step = dn_r ? (idx_r + CW'(1)) : (idx_r - CW'(1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_step[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_data = rd_data;
    case (state_r)
      S_IDLE: begin
        rd_addr = p0;
        rd_en   = accept && acc_ok &&
                  ((in_chan.op == OP_READ) || (in_chan.op == OP_REMOVE));
      end
      S_UP_RD, S_DN_RD: begin
        rd_en = 1'b1;
      end
      S_UP_WR, S_DN_WR: begin
        wr_en = 1'b1;
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = p0_r;
        wr_data = val_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      lim_r    <= '0;
      dn_r     <= 1'b0;
      status_r <= ST_OK;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            p0_r     <= p0;
            val_r    <= WIDTH'(in_chan.value);
            data_r   <= '0;
            status_r <= ST_OK;
            dn_r     <= (in_chan.op == OP_REMOVE);
            lim_r    <= count_r - CW'(1);
            case (in_chan.op)
              OP_READ: begin
                if (acc_ok) begin
                  state_r <= S_RD_WAIT;
                end else begin
                  status_r <= ST_RANGE;
                  state_r  <= S_DONE;
                end
              end
              OP_INSERT: begin
                if (!ins_ok) begin
                  status_r <= ST_RANGE;
                  state_r  <= S_DONE;
                end else if (full) begin
                  status_r <= ST_FULL;
                  state_r  <= S_DONE;
                end else if (append) begin
                  state_r <= S_INS_WR;
                end else begin
                  idx_r   <= count_r;
                  state_r <= S_UP_RD;
                end
              end
              OP_REMOVE: begin
                if (acc_ok) begin
                  idx_r   <= CW'(p0);
                  state_r <= S_RM_WAIT;
                end else begin
                  status_r <= ST_RANGE;
                  state_r  <= S_DONE;
                end
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          data_r  <= rd_data;
          state_r <= S_DONE;
        end
        S_UP_RD: begin
          state_r <= S_UP_WR;
        end
        S_UP_WR: begin
          if (idx_step == CW'(p0_r)) begin
            state_r <= S_INS_WR;
          end else begin
            idx_r   <= idx_step;
            state_r <= S_UP_RD;
          end
        end
        S_INS_WR: begin
          count_r <= count_r + CW'(1);
          state_r <= S_DONE;
        end
        S_RM_WAIT: begin
          data_r <= rd_data;
          if (idx_r == lim_r) begin
            count_r <= lim_r;
            state_r <= S_DONE;
          end else begin
            state_r <= S_DN_RD;
          end
        end
        S_DN_RD: begin
          state_r <= S_DN_WR;
        end
        S_DN_WR: begin
          if (idx_step == lim_r) begin
            count_r <= lim_r;
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_step;
            state_r <= S_DN_RD;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid     = (state_r == S_DONE);
  assign res.data      = DATA_W'(data_r);
  assign res.count     = CNT_W'(count_r);
  assign res.empty_res = (count_r == '0);
  assign res.status    = status_r;

endmodule

// ===== hw/rtl/positional_insert_remove_list.sv =====
// top level of the positional insert/remove list
// Ordered list of up to DEPTH entries of WIDTH bits, positions counted from 1.
// Op 0 reads the entry at a position, op 1 inserts a value in front of it
// (or right after the last entry), op 2 removes it; op 3 is a no-op. Every
// item gives one result with the data read or removed, the entry count after
// the operation, an empty flag and a status (ok, position out of range, full).
// Items are taken one at a time. The entries sit in a single memory with one
// write and one registered read port, and a small sequencer moves them one
// entry at a time (read, then write) when an insert or remove shifts the
// tail. With n entries before the item and position p, an insert shifts
// n-p+1 entries and a remove shifts n-p. The result sits in an output
// register, so the block goes back to accepting as soon as that register
// has room. Store contents are not cleared at reset; only the entry count
// is, and no entry at or beyond the count is ever read.
module positional_insert_remove_list #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  plr_in_if.sink     in_chan,
  plr_out_if.source  out_chan
);

  import plr_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // sequencer to output stage
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  // memory ports
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [WIDTH-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [WIDTH-1:0] rd_data;

  // output register
  logic             out_valid_r;
  res_t             out_res_r;

  plr_ctrl #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  plr_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register takes a new result when empty or being drained
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.data      = out_res_r.data;
  assign out_chan.count     = out_res_r.count;
  assign out_chan.empty_res = out_res_r.empty_res;
  assign out_chan.status    = out_res_r.status;

  // the sequencer never offers a result while it is taking a new item
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !res_valid)
    else $error("result pending while sequencer is idle");

  // a result handed over shows up on the output next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_chan.valid)
    else $error("handed-over result missing at output");

  // a full status is only reported with the store at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_FULL)) |-> (out_chan.count == CNT_W'(DEPTH)))
    else $error("full status with store below capacity");

endmodule
